// ----- hdl/htc_pkg.sv -----
// htc_pkg: widths, codes and constants for the hysteresis thermostat controller
// no dependencies; used by hysteresis_thermostat_controller

package htc_pkg;

    // width that holds the sum of the two thresholds when forming the heater band midpoint
    localparam int TEMP_WIDTH = 13;

    localparam int T_W     = 12;   // temperature and threshold fields
    localparam int MODE_W  = 2;
    localparam int CMD_W   = 2;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 7;
    localparam int CFG_IDX_W = 2;

    // datapath width for band arithmetic in half sixteenths, with room for signs
    localparam int DW = ((TEMP_WIDTH > T_W + 1) ? TEMP_WIDTH : (T_W + 1)) + 2;
    // width of the scaled dividend (100 times a band offset)
    localparam int NW = DW + LEVEL_W;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(100);
    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ON   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd2;

    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_IDLE = 2'd2;

    localparam logic signed [T_W-1:0] MIN_TEMP_RST = 12'sd320;
    localparam logic signed [T_W-1:0] MAX_TEMP_RST = 12'sd352;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_NORM  = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

// ----- hdl/hysteresis_thermostat_controller.sv -----
// hysteresis_thermostat_controller: thermostat with hysteresis switching, manual modes
// with timeout and proportional drive levels from a bit-serial restoring divider
// depends on htc_pkg
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tuser func, s_tdata sample or command
//  m_      | out       | m_tvalid/m_tready  | m_tdata commands, levels, flags, mode
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// one transaction at a time, through idle, eval and done; a drive level adds norm and
// check, and a divided level scale and the divider, which resolves one quotient bit a
// cycle. reset is synchronous, active low; no clearing pass. a finished result sits in the
// output register, so a new input is taken while m_tready is low; a second result then
// waits until the first transaction on m_ completes. cfg_ready is always high.

module hysteresis_thermostat_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // temperature[11:0], mode_cmd[13:12], hold_seconds[29:14], now_ms[61:30], zero fill
    input  logic [htc_pkg::S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // heater_cmd[1:0], idle_cmd[3:2], heater_level_valid[4], heater_level[11:5],
    // idle_level_valid[12], idle_level[19:13], heating_now[20], mode_now[22:21], zero fill
    output logic [htc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [htc_pkg::T_W-1:0]       cfg_data
);

    localparam int DW = htc_pkg::DW;
    localparam int NW = htc_pkg::NW;
    localparam int TW = htc_pkg::TEMP_WIDTH;
    localparam int LW = htc_pkg::LEVEL_W;

    htc_pkg::state_t state_reg, state_next;

    // configuration
    logic signed [htc_pkg::T_W-1:0] min_reg, min_next;
    logic signed [htc_pkg::T_W-1:0] max_reg, max_next;
    logic                           idle_unit_reg, idle_unit_next;
    logic signed [DW-1:0]           hband_lo_reg, hband_lo_next;

    // controller state
    logic                          heating_reg, heating_next;
    logic                          manual_reg, manual_next;
    logic [htc_pkg::MODE_W-1:0]    cur_mode_reg, cur_mode_next;
    logic [htc_pkg::MODE_W-1:0]    prev_mode_reg, prev_mode_next;
    logic                          dl_active_reg, dl_active_next;
    logic [htc_pkg::TIME_W-1:0]    dl_ms_reg, dl_ms_next;

    // captured input
    logic                          func_reg, func_next;
    logic signed [htc_pkg::T_W-1:0] temp_reg, temp_next;
    logic [htc_pkg::MODE_W-1:0]    mode_reg, mode_next;
    logic                          hold_nz_reg, hold_nz_next;
    logic [htc_pkg::TIME_W-1:0]    hold_ms_reg, hold_ms_next;
    logic [htc_pkg::TIME_W-1:0]    now_reg, now_next;

    // result under construction
    logic [htc_pkg::CMD_W-1:0]     hcmd_reg, hcmd_next;
    logic [htc_pkg::CMD_W-1:0]     icmd_reg, icmd_next;
    logic                          hval_reg, hval_next;
    logic                          ival_reg, ival_next;
    logic [LW-1:0]                 lvl_reg, lvl_next;

    // level datapath
    logic signed [DW-1:0]          num_reg, num_next;
    logic signed [DW-1:0]          den_reg, den_next;
    logic [NW-1:0]                 rem_reg, rem_next;
    logic [NW-1:0]                 dsr_reg, dsr_next;
    logic [LW-1:0]                 quo_reg, quo_next;
    logic [2:0]                    cnt_reg, cnt_next;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [htc_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // decision signals
    logic [htc_pkg::TIME_W-1:0]    elapsed;
    logic                          do_apply;
    logic [htc_pkg::MODE_W-1:0]    apply_mode;
    logic                          apply_hold;
    logic                          d_heating, d_manual, d_dl_active;
    logic [htc_pkg::MODE_W-1:0]    d_cur_mode, d_prev_mode;
    logic [htc_pkg::TIME_W-1:0]    d_dl_ms;
    logic [htc_pkg::CMD_W-1:0]     d_hcmd, d_icmd;
    logic                          d_hval, d_ival;

    logic [htc_pkg::TIME_W-1:0]    hold32;
    logic signed [DW-1:0]          lo2, hi2, t2, blo, thr_sum;
    logic [NW-1:0]                 diff_ext;
    logic [NW-1:0]                 rem_sub;
    logic                          rem_ge;

    assign s_tready  = (state_reg == htc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // thresholds and temperature doubled, so the band midpoint stays exact
    assign lo2 = {{(DW-htc_pkg::T_W-1){min_reg[htc_pkg::T_W-1]}}, min_reg, 1'b0};
    assign hi2 = {{(DW-htc_pkg::T_W-1){max_reg[htc_pkg::T_W-1]}}, max_reg, 1'b0};
    assign t2  = {{(DW-htc_pkg::T_W-1){temp_reg[htc_pkg::T_W-1]}}, temp_reg, 1'b0};
    assign thr_sum = DW'(min_reg) + DW'(max_reg);
    assign blo = d_hval ? hband_lo_reg : lo2;

    assign hold32   = {{(htc_pkg::TIME_W-htc_pkg::HOLD_W){1'b0}}, s_tdata[29:14]};
    assign diff_ext = {{(NW-DW){1'b0}}, num_reg};
    assign rem_ge   = (rem_reg >= dsr_reg);
    assign rem_sub  = rem_reg - dsr_reg;

    always_comb begin
        hband_lo_next = idle_unit_reg
            ? {{(DW-TW){thr_sum[TW-1]}}, thr_sum[TW-1:0]} : lo2;
    end

    // mode handling and hysteresis decision for the captured item
    always_comb begin
        elapsed    = now_reg - dl_ms_reg;
        do_apply   = func_reg || (manual_reg && dl_active_reg && !elapsed[htc_pkg::TIME_W-1]);
        apply_mode = func_reg ? mode_reg : prev_mode_reg;
        apply_hold = func_reg && hold_nz_reg;

        d_heating   = heating_reg;
        d_manual    = manual_reg;
        d_cur_mode  = cur_mode_reg;
        d_prev_mode = prev_mode_reg;
        d_dl_active = dl_active_reg;
        d_dl_ms     = dl_ms_reg;
        d_hcmd      = htc_pkg::CMD_NONE;
        d_icmd      = htc_pkg::CMD_NONE;
        d_hval      = 1'b0;
        d_ival      = 1'b0;

        if (do_apply) begin
            d_prev_mode = cur_mode_reg;
            case (apply_mode)
                htc_pkg::MODE_AUTO: begin
                    d_manual   = 1'b0;
                    d_cur_mode = htc_pkg::MODE_AUTO;
                end
                htc_pkg::MODE_ON: begin
                    d_heating  = 1'b1;
                    d_hcmd     = htc_pkg::CMD_START;
                    d_manual   = 1'b1;
                    d_cur_mode = htc_pkg::MODE_ON;
                end
                htc_pkg::MODE_OFF: begin
                    d_heating  = 1'b0;
                    d_hcmd     = htc_pkg::CMD_STOP;
                    d_manual   = 1'b1;
                    d_cur_mode = htc_pkg::MODE_OFF;
                end
                default: begin
                    // unrecognised command leaves mode and heating alone
                end
            endcase
            d_dl_active = apply_hold;
            d_dl_ms     = apply_hold ? (now_reg + hold_ms_reg) : '0;
        end

        if (!func_reg) begin
            if (manual_reg) begin
                d_hval = d_heating;
            end else if (heating_reg && (temp_reg >= max_reg)) begin
                d_heating = 1'b0;
                d_hcmd    = htc_pkg::CMD_STOP;
                if (idle_unit_reg) begin
                    d_icmd = htc_pkg::CMD_START;
                end
            end else if (!heating_reg && (temp_reg <= min_reg)) begin
                d_heating = 1'b1;
                d_hcmd    = htc_pkg::CMD_START;
                if (idle_unit_reg) begin
                    d_icmd = htc_pkg::CMD_STOP;
                end
            end else if (heating_reg) begin
                d_hval = 1'b1;
            end else begin
                d_ival = idle_unit_reg;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        idle_unit_next = idle_unit_reg;
        heating_next   = heating_reg;
        manual_next    = manual_reg;
        cur_mode_next  = cur_mode_reg;
        prev_mode_next = prev_mode_reg;
        dl_active_next = dl_active_reg;
        dl_ms_next     = dl_ms_reg;
        func_next      = func_reg;
        temp_next      = temp_reg;
        mode_next      = mode_reg;
        hold_nz_next   = hold_nz_reg;
        hold_ms_next   = hold_ms_reg;
        now_next       = now_reg;
        hcmd_next      = hcmd_reg;
        icmd_next      = icmd_reg;
        hval_next      = hval_reg;
        ival_next      = ival_reg;
        lvl_next       = lvl_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dsr_next       = dsr_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (cfg_valid) begin
            case (cfg_index)
                htc_pkg::CFG_MIN_TEMP: min_next = cfg_data;
                htc_pkg::CFG_MAX_TEMP: max_next = cfg_data;
                htc_pkg::CFG_HAS_IDLE: idle_unit_next = cfg_data[0];
                default: begin
                end
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            htc_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    func_next    = s_tuser;
                    temp_next    = s_tdata[11:0];
                    mode_next    = s_tdata[13:12];
                    hold_nz_next = (s_tdata[29:14] != '0);
                    // seconds to milliseconds: 1024 - 16 - 8
                    hold_ms_next = (hold32 << 10) - (hold32 << 4) - (hold32 << 3);
                    now_next     = s_tdata[61:30];
                    state_next   = htc_pkg::ST_EVAL;
                end
            end
            htc_pkg::ST_EVAL: begin
                heating_next   = d_heating;
                manual_next    = d_manual;
                cur_mode_next  = d_cur_mode;
                prev_mode_next = d_prev_mode;
                dl_active_next = d_dl_active;
                dl_ms_next     = d_dl_ms;
                hcmd_next      = d_hcmd;
                icmd_next      = d_icmd;
                hval_next      = d_hval;
                ival_next      = d_ival;
                num_next       = t2 - blo;
                den_next       = hi2 - blo;
                lvl_next       = htc_pkg::LEVEL_ZERO;
                state_next     = (d_hval || d_ival) ? htc_pkg::ST_NORM : htc_pkg::ST_DONE;
            end
            htc_pkg::ST_NORM: begin
                // inverted band: flip both so the ratio keeps its sign
                if (den_reg[DW-1]) begin
                    den_next = -den_reg;
                    num_next = -num_reg;
                end
                state_next = htc_pkg::ST_CHECK;
            end
            htc_pkg::ST_CHECK: begin
                // also covers the zero width band
                if (num_reg <= 0) begin
                    lvl_next   = htc_pkg::LEVEL_FULL;
                    state_next = htc_pkg::ST_DONE;
                end else if (num_reg >= den_reg) begin
                    lvl_next   = htc_pkg::LEVEL_ZERO;
                    state_next = htc_pkg::ST_DONE;
                end else begin
                    num_next   = den_reg - num_reg;
                    state_next = htc_pkg::ST_SCALE;
                end
            end
            htc_pkg::ST_SCALE: begin
                // times 100 as 64 + 32 + 4; quotient is below 100 so 7 bits suffice
                rem_next   = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
                dsr_next   = {{(NW-DW){1'b0}}, den_reg} << (LW - 1);
                quo_next   = '0;
                cnt_next   = '0;
                state_next = htc_pkg::ST_DIV;
            end
            htc_pkg::ST_DIV: begin
                if (rem_ge) begin
                    rem_next = rem_sub;
                end
                quo_next = {quo_reg[LW-2:0], rem_ge};
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(LW - 1)) begin
                    lvl_next   = {quo_reg[LW-2:0], rem_ge};
                    state_next = htc_pkg::ST_DONE;
                end
            end
            htc_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, cur_mode_reg, heating_reg,
                                     ival_reg ? lvl_reg : htc_pkg::LEVEL_ZERO, ival_reg,
                                     hval_reg ? lvl_reg : htc_pkg::LEVEL_ZERO, hval_reg,
                                     icmd_reg, hcmd_reg};
                    state_next    = htc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = htc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= htc_pkg::ST_IDLE;
            min_reg       <= htc_pkg::MIN_TEMP_RST;
            max_reg       <= htc_pkg::MAX_TEMP_RST;
            idle_unit_reg <= 1'b1;
            heating_reg   <= 1'b0;
            manual_reg    <= 1'b0;
            cur_mode_reg  <= htc_pkg::MODE_AUTO;
            prev_mode_reg <= htc_pkg::MODE_AUTO;
            dl_active_reg <= 1'b0;
            dl_ms_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            idle_unit_reg <= idle_unit_next;
            heating_reg   <= heating_next;
            manual_reg    <= manual_next;
            cur_mode_reg  <= cur_mode_next;
            prev_mode_reg <= prev_mode_next;
            dl_active_reg <= dl_active_next;
            dl_ms_reg     <= dl_ms_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hband_lo_reg <= hband_lo_next;
        func_reg     <= func_next;
        temp_reg     <= temp_next;
        mode_reg     <= mode_next;
        hold_nz_reg  <= hold_nz_next;
        hold_ms_reg  <= hold_ms_next;
        now_reg      <= now_next;
        hcmd_reg     <= hcmd_next;
        icmd_reg     <= icmd_next;
        hval_reg     <= hval_next;
        ival_reg     <= ival_next;
        lvl_reg      <= lvl_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // a new result only ever comes out of the final state
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == htc_pkg::ST_DONE))
        else $error("result loaded outside the final state");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(m_tdata_reg))
        else $error("stalled result changed");

    // at most one unit is driven per result
    a_one_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[4] && m_tdata_reg[12]))
        else $error("both drive levels valid");

    // the divider finishes within its step count
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == htc_pkg::ST_DIV) |-> (cnt_reg <= 3'(LW - 1)))
        else $error("divider ran past its last step");

    // starting the heater always leaves heating set
    a_start_heats: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == htc_pkg::ST_EVAL && d_hcmd == htc_pkg::CMD_START) |=> heating_reg)
        else $error("heater started without heating flag");

endmodule

// ----- dv/htc_checker.sv -----
// htc_checker: keeps its own copy of the thermostat state and registers, predicts each result
// from the accepted samples, mode commands and register writes, and compares field by field
// depends on htc_pkg; instantiated beside the block by tb_top

module htc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [htc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [htc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [htc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [htc_pkg::T_W-1:0]         cfg_data,
    output int                              errors,
    output int                              n_due
);
    import htc_pkg::*;

    localparam int PERCENT   = 100;
    localparam int MS_PER_S  = 1000;

    typedef struct packed {
        logic [CMD_W-1:0]   heater_cmd;
        logic [CMD_W-1:0]   idle_cmd;
        logic               heater_level_valid;
        logic [LEVEL_W-1:0] heater_level;
        logic               idle_level_valid;
        logic [LEVEL_W-1:0] idle_level;
        logic               heating_now;
        logic [MODE_W-1:0]  mode_now;
    } thermo_out_t;

    // register copies
    logic signed [T_W-1:0] thr_lo;
    logic signed [T_W-1:0] thr_hi;
    logic                  idle_fitted;

    // thermostat state
    logic                  heating;
    logic                  manual;
    logic [MODE_W-1:0]     mode_cur;
    logic [MODE_W-1:0]     mode_prev;
    logic                  dl_armed;
    logic [TIME_W-1:0]     dl_at;

    thermo_out_t           due_outputs[$];

    // 100 minus the clamped position of t in the band lo..hi, truncated
    function automatic logic [LEVEL_W-1:0] band_level(input int lo, input int hi, input int t);
        int span;
        int off;
        span = hi - lo;
        off  = t - lo;
        if (span == 0)
            return (off <= 0) ? LEVEL_FULL : LEVEL_ZERO;
        if (span < 0) begin
            span = -span;
            off  = -off;
        end
        if (off <= 0)
            return LEVEL_FULL;
        if (off >= span)
            return LEVEL_ZERO;
        return LEVEL_W'((PERCENT * (span - off)) / span);
    endfunction

    // heater band low end in half sixteenths; the midpoint sum wraps at TEMP_WIDTH bits
    function automatic int heater_band_lo();
        logic signed [TEMP_WIDTH-1:0] mid_sum;
        mid_sum = TEMP_WIDTH'(int'(thr_lo) + int'(thr_hi));
        return idle_fitted ? int'(mid_sum) : 2 * int'(thr_lo);
    endfunction

    function automatic logic [CMD_W-1:0] switch_mode(input logic [MODE_W-1:0] m,
                                                     input logic [HOLD_W-1:0] hold,
                                                     input logic [TIME_W-1:0] now);
        logic [CMD_W-1:0] cmd;
        cmd       = CMD_NONE;
        mode_prev = mode_cur;
        case (m)
            MODE_AUTO: begin
                manual   = 1'b0;
                mode_cur = MODE_AUTO;
            end
            MODE_ON: begin
                heating  = 1'b1;
                cmd      = CMD_START;
                manual   = 1'b1;
                mode_cur = MODE_ON;
            end
            MODE_OFF: begin
                heating  = 1'b0;
                cmd      = CMD_STOP;
                manual   = 1'b1;
                mode_cur = MODE_OFF;
            end
            default: ;  // unrecognised: only the previous mode and the deadline move
        endcase
        dl_armed = (hold != '0);
        dl_at    = (hold != '0) ? now + TIME_W'(hold) * TIME_W'(MS_PER_S) : '0;
        return cmd;
    endfunction

    function automatic thermo_out_t thermostat_step(input logic is_cmd,
                                                    input logic [S_TDATA_W-1:0] d);
        thermo_out_t           r;
        logic signed [T_W-1:0] t_raw;
        logic [MODE_W-1:0]     m;
        logic [HOLD_W-1:0]     hold;
        logic [TIME_W-1:0]     now;
        logic [TIME_W-1:0]     since;
        int                    t;
        int                    lo;
        int                    hi;
        t_raw = d[11:0];
        m     = d[13:12];
        hold  = d[29:14];
        now   = d[61:30];
        t     = int'(t_raw);
        lo    = int'(thr_lo);
        hi    = int'(thr_hi);
        r     = '0;
        if (is_cmd) begin
            r.heater_cmd = switch_mode(m, hold, now);
        end else if (manual) begin
            // deadline passed when the wrapped difference is below half the counter range
            since = now - dl_at;
            if (dl_armed && !since[TIME_W-1])
                r.heater_cmd = switch_mode(mode_prev, '0, now);
            if (heating) begin
                r.heater_level_valid = 1'b1;
                r.heater_level       = band_level(heater_band_lo(), 2 * hi, 2 * t);
            end
        end else if (heating && t >= hi) begin
            heating      = 1'b0;
            r.heater_cmd = CMD_STOP;
            if (idle_fitted)
                r.idle_cmd = CMD_START;
        end else if (!heating && t <= lo) begin
            if (idle_fitted)
                r.idle_cmd = CMD_STOP;
            heating      = 1'b1;
            r.heater_cmd = CMD_START;
        end else if (heating) begin
            r.heater_level_valid = 1'b1;
            r.heater_level       = band_level(heater_band_lo(), 2 * hi, 2 * t);
        end else if (idle_fitted) begin
            r.idle_level_valid = 1'b1;
            r.idle_level       = band_level(lo, hi, t);
        end
        r.heating_now = heating;
        r.mode_now    = mode_cur;
        return r;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge aclk) begin : watch
        thermo_out_t got;
        thermo_out_t want;
        if (!aresetn) begin
            thr_lo      = MIN_TEMP_RST;
            thr_hi      = MAX_TEMP_RST;
            idle_fitted = 1'b1;
            heating     = 1'b0;
            manual      = 1'b0;
            mode_cur    = MODE_AUTO;
            mode_prev   = MODE_AUTO;
            dl_armed    = 1'b0;
            dl_at       = '0;
            due_outputs.delete();
            errors      = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_MIN_TEMP: thr_lo = cfg_data;
                    CFG_MAX_TEMP: thr_hi = cfg_data;
                    CFG_HAS_IDLE: idle_fitted = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.heater_cmd         = m_tdata[1:0];
                got.idle_cmd           = m_tdata[3:2];
                got.heater_level_valid = m_tdata[4];
                got.heater_level       = m_tdata[11:5];
                got.idle_level_valid   = m_tdata[12];
                got.idle_level         = m_tdata[19:13];
                got.heating_now        = m_tdata[20];
                got.mode_now           = m_tdata[22:21];
                if (due_outputs.size() == 0) begin
                    $error("result transaction with nothing expected: m_tdata %h", m_tdata);
                    errors = errors + 1;
                end else begin
                    want = due_outputs.pop_front();
                    compare_field("heater_cmd", int'(want.heater_cmd), int'(got.heater_cmd));
                    compare_field("idle_cmd", int'(want.idle_cmd), int'(got.idle_cmd));
                    compare_field("heater_level_valid", int'(want.heater_level_valid),
                                  int'(got.heater_level_valid));
                    compare_field("heater_level", int'(want.heater_level),
                                  int'(got.heater_level));
                    compare_field("idle_level_valid", int'(want.idle_level_valid),
                                  int'(got.idle_level_valid));
                    compare_field("idle_level", int'(want.idle_level), int'(got.idle_level));
                    compare_field("heating_now", int'(want.heating_now),
                                  int'(got.heating_now));
                    compare_field("mode_now", int'(want.mode_now), int'(got.mode_now));
                end
            end
            if (s_tvalid && s_tready)
                due_outputs.push_back(thermostat_step(s_tuser, s_tdata));
        end
        n_due = due_outputs.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// tb_top: stimulus and verdict for hysteresis_thermostat_controller; directed samples and
// mode commands, then random temperature walks over several register settings
// depends on htc_pkg, hysteresis_thermostat_controller and htc_checker

module tb_top;
    import htc_pkg::*;

    localparam int LIMIT        = 200000;
    localparam int HOLD_OFF     = 200;
    localparam int SETTLE       = 20;
    localparam int PHASES       = 7;
    localparam int RANDOM_ITEMS = 525;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_MODE   = 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [T_W-1:0]       cfg_data;

    int                   errors;
    int                   n_due;
    int                   cycles;
    bit                   no_idling;
    bit                   stall_output;
    int                   lo_now;
    int                   hi_now;
    int                   temp_walk;
    logic [TIME_W-1:0]    clock_ms;

    hysteresis_thermostat_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    htc_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .n_due     (n_due)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("hysteresis_thermostat_controller regression: fail");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off while the sender keeps offering
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge aclk);
                stall_output = 1'b0;
                m_tready <= 1'b1;
            end else if (!no_idling && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic func, input int temp, input logic [MODE_W-1:0] mode,
                         input logic [HOLD_W-1:0] hold, input logic [TIME_W-1:0] now);
        @(negedge aclk);
        if (!no_idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, now, hold, mode, T_W'(temp)};
        do @(posedge aclk); while (!s_tready);
    endtask

    // unused command fields carry noise
    task automatic sample(input int temp);
        offer(FUNC_SAMPLE, temp, MODE_W'($urandom_range(0, 3)), HOLD_W'($urandom()), clock_ms);
    endtask

    task automatic command(input logic [MODE_W-1:0] mode, input logic [HOLD_W-1:0] hold);
        offer(FUNC_MODE, int'($urandom_range(0, 4095)) - 2048, mode, hold, clock_ms);
    endtask

    // sender pauses until every result has come back
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (n_due != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= T_W'(value);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input int lo, input int hi, input bit idle);
        drain();
        write_reg(CFG_MIN_TEMP, lo);
        write_reg(CFG_MAX_TEMP, hi);
        write_reg(CFG_HAS_IDLE, int'(idle));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        lo_now = lo;
        hi_now = hi;
    endtask

    // temperature walks through the band so that the hysteresis switches both ways
    task automatic random_item();
        int band_lo;
        int band_hi;
        int step;
        band_lo = (lo_now < hi_now) ? lo_now : hi_now;
        band_hi = (lo_now < hi_now) ? hi_now : lo_now;
        step    = (band_hi - band_lo) / 16;
        if (step < 8)
            step = 8;
        if ($urandom_range(0, 49) == 0)
            clock_ms = $urandom();
        else
            clock_ms = clock_ms + $urandom_range(0, 2500);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: command(MODE_W'($urandom_range(0, 3)), '0);
                9:          command(MODE_W'($urandom_range(0, 3)), HOLD_W'($urandom()));
                default:    command(MODE_W'($urandom_range(0, 3)),
                                    HOLD_W'($urandom_range(1, 4)));
            endcase
        end else begin
            if ($urandom_range(0, 19) == 0) begin
                temp_walk = int'($urandom_range(0, 4095)) - 2048;
            end else begin
                temp_walk = temp_walk + int'($urandom_range(0, 2 * step)) - step;
                if (temp_walk < band_lo - 48 || temp_walk > band_hi + 48)
                    temp_walk = band_lo - 48 + int'($urandom_range(0, band_hi - band_lo + 96));
            end
            if (temp_walk < -2048)
                temp_walk = -2048;
            if (temp_walk > 2047)
                temp_walk = 2047;
            sample(temp_walk);
        end
    endtask

    initial begin
        int lo;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_SAMPLE;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_TEMP;
        cfg_data  = '0;
        clock_ms  = '0;
        lo_now    = int'(MIN_TEMP_RST);
        hi_now    = int'(MAX_TEMP_RST);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part on the reset thresholds, idle unit fitted
        sample(336);
        sample(352);
        sample(321);
        sample(320);                    // switch on: heater starts, idle unit stops
        sample(344);
        sample(330);                    // below the heater band midpoint
        sample(351);
        sample(352);                    // switch off
        sample(-2048);
        sample(2047);
        sample(-880);
        sample(2000);
        clock_ms = 32'd1000;
        command(MODE_ON, '0);
        sample(340);
        clock_ms = 32'd2000;
        command(MODE_OFF, 16'd5);       // timeout back to on at 7000 ms
        clock_ms = 32'd6999;
        sample(340);
        clock_ms = 32'd7000;
        sample(300);
        clock_ms = 32'hFFFF_FFFF;
        command(MODE_UNKNOWN, 16'hFFFF);    // deadline wraps past zero
        clock_ms = 32'd0;
        sample(340);
        clock_ms = 32'h8000_0000;
        sample(340);
        command(MODE_OFF, '0);
        command(MODE_AUTO, '0);
        sample(336);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(300, 420, 1'b0);
                1: configure(-880, 2000, 1'b1);
                2: configure(400, 400, 1'b1);       // zero width band
                3: configure(500, 380, 1'b1);       // inverted band
                4: configure(-2048, 2047, 1'b0);
                5: configure(2047, -2048, 1'b1);
                default: begin
                    lo = -880 + int'($urandom_range(0, 2640));
                    configure(lo, lo + int'($urandom_range(0, 240)),
                              1'($urandom_range(0, 1)));
                end
            endcase
            @(posedge aclk);
            if (p == 1)
                stall_output = 1'b1;
            if (p == PHASES - 1)
                no_idling = 1'b1;
            temp_walk = lo_now + (hi_now - lo_now) / 2;
            repeat (RANDOM_ITEMS / PHASES) random_item();
        end

        drain();
        if (errors == 0 && n_due == 0)
            $display("hysteresis_thermostat_controller regression: pass");
        else
            $display("hysteresis_thermostat_controller regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/htc_pkg.sv
hdl/hysteresis_thermostat_controller.sv
dv/htc_checker.sv
dv/tb_top.sv
